// ===== rtl/fifo_with_index_and_search_core_defines.svh =====
// Assertion macros shared by the queue RTL.
`ifndef FIFO_WITH_INDEX_AND_SEARCH_CORE_DEFINES_SVH
`define FIFO_WITH_INDEX_AND_SEARCH_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define FWIS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FWIS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/fwis_pkg.sv =====
// Types and constants for the indexed, searchable queue.
`default_nettype none

package fwis_pkg;

	localparam int DEPTH     = 16;                 // power of two: slot pointers wrap
	localparam int WORD_BITS = 32;
	localparam int SLOT_BITS = $clog2(DEPTH);
	localparam int CNT_BITS  = $clog2(DEPTH + 1);
	localparam int POS_BITS  = 8;
	localparam int FPOS_BITS = 4;
	localparam int OCC_BITS  = 5;
	localparam int S_DATA_BITS = 40;
	localparam int M_DATA_BITS = 48;

	typedef enum logic [1:0] {
		MODE_PUSH   = 2'd0,
		MODE_POP    = 2'd1,
		MODE_READ   = 2'd2,
		MODE_SEARCH = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2,
		STAT_MISS  = 2'd3
	} status_t;

endpackage

`default_nettype wire

// ===== rtl/fifo_with_index_and_search_core.sv =====
// Queue of words with pop, indexed read and first-match search over one memory.
`default_nettype none

// Sixteen-entry queue of 32-bit words held in a circular store in a single
// synchronous RAM (one write port, one read port, registered read data).
// One operation per input beat, one result beat per operation, in order.
// The core handles one operation at a time: a push, or any operation that
// fails at once (full, empty, bad position), goes from idle straight to the
// done state; pop and read pass through a fetch state (RAM read, then
// result). A search reads the stored words through the RAM read port one per
// cycle from the oldest to the first match. Results leave through an output
// register, so the next beat is taken while a result waits on m_tready.
// No clearing pass after reset: entries are only ever read once written.
module fifo_with_index_and_search_core (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  s_tvalid,
	output logic                                 s_tready,
	input  wire  [fwis_pkg::S_DATA_BITS-1:0]     s_tdata,  // value[31:0], position[39:32]
	input  fwis_pkg::mode_t                      s_tuser,  // mode
	output logic                                 m_tvalid,
	input  wire                                  m_tready,
	output logic [fwis_pkg::M_DATA_BITS-1:0]     m_tdata,  // data[31:0], found_position[35:32],
	                                                       // occupancy[40:36], is_empty[41],
	                                                       // is_full[42], zero[47:43]
	output fwis_pkg::status_t                    m_tuser   // status
);
	import fwis_pkg::*;

	`include "fifo_with_index_and_search_core_defines.svh"

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_FETCH = 4'b0010,
		ST_SCAN  = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t                 state_q;
	logic [SLOT_BITS-1:0]   oldest_q;
	logic [CNT_BITS-1:0]    count_q;
	logic [CNT_BITS-1:0]    idx_q;
	mode_t                  mode_q;
	logic [WORD_BITS-1:0]   value_q;

	logic [WORD_BITS-1:0]   res_data_q;
	status_t                res_status_q;
	logic [FPOS_BITS-1:0]   res_found_q;

	logic                   out_valid_q;
	logic [WORD_BITS-1:0]   out_data_q;
	status_t                out_status_q;
	logic [FPOS_BITS-1:0]   out_found_q;
	logic [OCC_BITS-1:0]    out_occ_q;
	logic                   out_empty_q;
	logic                   out_full_q;

	logic [WORD_BITS-1:0]   mem [DEPTH];
	logic [WORD_BITS-1:0]   rd_data_s1;
	logic                   mem_we;
	logic [SLOT_BITS-1:0]   mem_waddr;
	logic                   mem_re;
	logic [SLOT_BITS-1:0]   mem_raddr;

	logic                   in_fire;
	logic [WORD_BITS-1:0]   in_value;
	logic [POS_BITS-1:0]    in_pos;
	logic                   q_empty;
	logic                   q_full;
	logic                   pos_bad;
	logic                   scan_hit;
	logic                   scan_last;
	logic                   out_free;
	logic [CNT_BITS-1:0]    idx_nxt;

	assign s_tready  = (state_q == ST_IDLE);
	assign in_fire   = s_tvalid && s_tready;
	assign in_value  = s_tdata[WORD_BITS-1:0];
	assign in_pos    = s_tdata[WORD_BITS +: POS_BITS];
	assign q_empty   = (count_q == '0);
	assign q_full    = (count_q == CNT_BITS'(DEPTH));
	assign pos_bad   = (in_pos >= POS_BITS'(count_q));
	assign scan_hit  = (rd_data_s1 == value_q);
	assign idx_nxt   = idx_q + CNT_BITS'(1);
	assign scan_last = (idx_nxt == count_q);
	assign out_free  = !out_valid_q || m_tready;

	// RAM port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = oldest_q + count_q[SLOT_BITS-1:0];
		mem_re    = 1'b0;
		mem_raddr = oldest_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					case (s_tuser)
						MODE_PUSH:   mem_we = !q_full;
						MODE_POP:    mem_re = !q_empty;
						MODE_READ: begin
							mem_re    = !q_empty && !pos_bad;
							mem_raddr = oldest_q + in_pos[SLOT_BITS-1:0];
						end
						MODE_SEARCH: mem_re = !q_empty;
						default:     mem_re = 1'b0;
					endcase
				end
			end
			ST_SCAN: begin
				// fetch the next entry while the current one is compared
				mem_re    = !scan_hit && !scan_last;
				mem_raddr = oldest_q + idx_nxt[SLOT_BITS-1:0];
			end
			default: mem_re = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= in_value;
		end
		if (mem_re) begin
			rd_data_s1 <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			oldest_q    <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						mode_q       <= s_tuser;
						value_q      <= in_value;
						idx_q        <= '0;
						res_data_q   <= '0;
						res_found_q  <= '0;
						res_status_q <= STAT_OK;
						state_q      <= ST_DONE;
						case (s_tuser)
							MODE_PUSH: begin
								if (q_full) begin
									res_status_q <= STAT_FULL;
								end else begin
									count_q <= count_q + CNT_BITS'(1);
								end
							end
							MODE_POP: begin
								if (q_empty) begin
									res_status_q <= STAT_EMPTY;
								end else begin
									state_q <= ST_FETCH;
								end
							end
							MODE_READ: begin
								if (q_empty) begin
									res_status_q <= STAT_EMPTY;
								end else if (pos_bad) begin
									res_status_q <= STAT_MISS;
								end else begin
									state_q <= ST_FETCH;
								end
							end
							MODE_SEARCH: begin
								if (q_empty) begin
									res_status_q <= STAT_EMPTY;
								end else begin
									state_q <= ST_SCAN;
								end
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_FETCH: begin
					res_data_q <= rd_data_s1;
					if (mode_q == MODE_POP) begin
						oldest_q <= oldest_q + SLOT_BITS'(1);
						count_q  <= count_q - CNT_BITS'(1);
					end
					state_q <= ST_DONE;
				end
				ST_SCAN: begin
					if (scan_hit) begin
						res_found_q <= idx_q[FPOS_BITS-1:0];
						state_q     <= ST_DONE;
					end else if (scan_last) begin
						res_status_q <= STAT_MISS;
						state_q      <= ST_DONE;
					end else begin
						idx_q <= idx_nxt;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result beat payload, taken from the queue state after the operation
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_data_q   <= res_data_q;
			out_status_q <= res_status_q;
			out_found_q  <= res_found_q;
			out_occ_q    <= OCC_BITS'(count_q);
			out_empty_q  <= q_empty;
			out_full_q   <= q_full;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {5'b0, out_full_q, out_empty_q, out_occ_q, out_found_q, out_data_q};

	`FWIS_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CNT_BITS'(DEPTH),
		"entry count beyond capacity")
	`FWIS_ASSERT_IMP(a_scan_in_range, state_q == ST_SCAN, idx_q < count_q,
		"search index past stored entries")
	`FWIS_ASSERT_NXT(a_push_grows, in_fire && s_tuser == MODE_PUSH && !q_full,
		count_q == $past(count_q) + CNT_BITS'(1), "push did not grow the queue")
	`FWIS_ASSERT_NXT(a_pop_advances, state_q == ST_FETCH && mode_q == MODE_POP,
		oldest_q == $past(oldest_q) + SLOT_BITS'(1), "pop did not advance oldest slot")
	`FWIS_ASSERT_IMP(a_flags_match, out_valid_q,
		out_empty_q == (out_occ_q == '0), "empty flag disagrees with occupancy")

endmodule

`default_nettype wire
